// ===== design/rld_pkg.sv =====
package rld_pkg;

    typedef enum logic [3:0] {
        PH_DONE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_LENGTH = 4'b0100,
        PH_OFFSET = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        KIND_RUN        = 3'd0,
        KIND_RUN_LIMIT  = 3'd1,
        KIND_END        = 3'd2,
        KIND_NOT_NONRES = 3'd3,
        KIND_ENCRYPTED  = 3'd4,
        KIND_COMPRESSED = 3'd5,
        KIND_BAD_SIZE   = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        REG_START_VCN   = 3'd0,
        REG_VALID_BYTES = 3'd1,
        REG_CLUSTER_LOG = 3'd2,
        REG_NONRESIDENT = 3'd3,
        REG_ENCRYPTED   = 3'd4,
        REG_COMPRESSED  = 3'd5
    } reg_index_t;

    localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;
    localparam logic [4:0] CLUSTER_LOG_RESET = 5'd12;

endpackage

// ===== design/run_list_decoder.sv =====
// An accepted input beat is held in the input register, and any result beat
// it yields is then captured in the result register. Throughput: one byte
// per cycle; a byte waits only while the result register is full and m_ready
// is low. Reset (aresetn low, synchronous) clears the parser to finished,
// empties both registers and loads the configuration reset values; the
// cluster limit follows a configuration write through its own register.
module run_list_decoder import rld_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_stream_byte,
    input  logic        s_first_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_result_kind,
    output logic [63:0] m_run_vcn,
    output logic [63:0] m_run_lcn,
    output logic [63:0] m_run_length,
    output logic        m_run_sparse,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // configuration
    logic [62:0] start_vcn_reg;
    logic [62:0] valid_bytes_reg;
    logic [4:0]  cluster_log2_reg;
    logic        nonres_reg;
    logic        encrypted_reg;
    logic        compressed_reg;
    logic [63:0] cfg_limit_reg;
    logic [62:0] limit_shift;
    logic [62:0] rem_mask;
    logic [63:0] cfg_limit_next;

    // input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic        proceed;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [3:0]  len_cnt_reg, len_cnt_next;
    logic [3:0]  off_cnt_reg, off_cnt_next;
    logic [3:0]  left_reg, left_next;
    logic [63:0] len_acc_reg, len_acc_next;
    logic [63:0] off_acc_reg, off_acc_next;
    logic [63:0] next_vcn_reg, next_vcn_next;
    logic [63:0] cur_lcn_reg, cur_lcn_next;
    logic [63:0] limit_reg, limit_next;

    // result stage
    logic        m_valid_reg;
    kind_t       kind_reg;
    logic [63:0] vcn_reg;
    logic [63:0] lcn_reg;
    logic [63:0] length_reg;
    logic        sparse_reg;

    // combinational work
    logic        res_valid;
    kind_t       res_kind;
    logic [63:0] res_vcn;
    logic [63:0] res_lcn;
    logic [63:0] res_len;
    logic        res_sparse;
    logic        do_header;
    logic        do_finish;
    logic [3:0]  hdr_len;
    logic [3:0]  hdr_off;
    logic [2:0]  len_idx;
    logic [2:0]  off_idx;
    logic [63:0] len_merged;
    logic [63:0] off_merged;
    logic [63:0] len_fin;
    logic [63:0] off_fin;
    logic [63:0] off_ext;
    logic [63:0] end_raw;
    logic [63:0] run_end;
    logic [63:0] lcn_sum;
    logic        run_sparse;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_vcn_reg    <= '0;
            valid_bytes_reg  <= '0;
            cluster_log2_reg <= CLUSTER_LOG_RESET;
            nonres_reg       <= 1'b1;
            encrypted_reg    <= 1'b0;
            compressed_reg   <= 1'b0;
            cfg_limit_reg    <= '0;
        end else begin
            cfg_limit_reg <= cfg_limit_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_START_VCN:   start_vcn_reg    <= cfg_data[62:0];
                    REG_VALID_BYTES: valid_bytes_reg  <= cfg_data[62:0];
                    REG_CLUSTER_LOG: cluster_log2_reg <= cfg_data[4:0];
                    REG_NONRESIDENT: nonres_reg       <= cfg_data[0];
                    REG_ENCRYPTED:   encrypted_reg    <= cfg_data[0];
                    REG_COMPRESSED:  compressed_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // cluster limit: round valid bytes up to whole clusters
    always_comb begin
        limit_shift    = valid_bytes_reg >> cluster_log2_reg;
        rem_mask       = (63'd1 << cluster_log2_reg) - 63'd1;
        cfg_limit_next = {1'b0, limit_shift} + {63'd0, |(valid_bytes_reg & rem_mask)};
    end

    assign proceed = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proceed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proceed) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_stream_byte;
            in_first_reg <= s_first_byte;
        end
    end

    // byte merge and run arithmetic
    always_comb begin
        hdr_len    = in_byte_reg[3:0];
        hdr_off    = in_byte_reg[7:4];
        len_idx    = 3'(len_cnt_reg - left_reg);
        off_idx    = 3'(off_cnt_reg - left_reg);
        len_merged = len_acc_reg | ({56'd0, in_byte_reg} << {len_idx, 3'b000});
        off_merged = off_acc_reg | ({56'd0, in_byte_reg} << {off_idx, 3'b000});
        len_fin    = (phase_reg == PH_LENGTH) ? len_merged : len_acc_reg;
        off_fin    = (phase_reg == PH_OFFSET) ? off_merged : off_acc_reg;
        run_sparse = (off_cnt_reg == 4'd0);
        case (off_cnt_reg)
            4'd1:    off_ext = {{56{off_fin[7]}},  off_fin[7:0]};
            4'd2:    off_ext = {{48{off_fin[15]}}, off_fin[15:0]};
            4'd3:    off_ext = {{40{off_fin[23]}}, off_fin[23:0]};
            4'd4:    off_ext = {{32{off_fin[31]}}, off_fin[31:0]};
            4'd5:    off_ext = {{24{off_fin[39]}}, off_fin[39:0]};
            4'd6:    off_ext = {{16{off_fin[47]}}, off_fin[47:0]};
            4'd7:    off_ext = {{8{off_fin[55]}},  off_fin[55:0]};
            default: off_ext = off_fin;
        endcase
        end_raw = next_vcn_reg + len_fin;
        lcn_sum = cur_lcn_reg + off_ext;
        if (!run_sparse && (end_raw > limit_reg)) begin
            run_end = limit_reg;
        end else begin
            run_end = end_raw;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        len_cnt_next  = len_cnt_reg;
        off_cnt_next  = off_cnt_reg;
        left_next     = left_reg;
        len_acc_next  = len_acc_reg;
        off_acc_next  = off_acc_reg;
        next_vcn_next = next_vcn_reg;
        cur_lcn_next  = cur_lcn_reg;
        limit_next    = limit_reg;
        res_valid     = 1'b0;
        res_kind      = KIND_RUN;
        res_vcn       = '0;
        res_lcn       = '0;
        res_len       = '0;
        res_sparse    = 1'b0;
        do_header     = 1'b0;
        do_finish     = 1'b0;

        if (proceed) begin
            if (in_first_reg) begin
                next_vcn_next = {1'b0, start_vcn_reg};
                cur_lcn_next  = '0;
                len_acc_next  = '0;
                off_acc_next  = '0;
                left_next     = '0;
                len_cnt_next  = '0;
                off_cnt_next  = '0;
                if (!nonres_reg) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_NOT_NONRES;
                end else if (encrypted_reg) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_ENCRYPTED;
                end else if (compressed_reg) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_COMPRESSED;
                end else begin
                    limit_next = cfg_limit_reg;
                    if (cfg_limit_reg == 64'd0) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_END;
                    end else begin
                        do_header = 1'b1;
                    end
                end
                if (res_valid) begin
                    phase_next = PH_DONE;
                end
            end else begin
                case (phase_reg)
                    PH_HEADER: begin
                        do_header = 1'b1;
                    end
                    PH_LENGTH: begin
                        len_acc_next = len_merged;
                        left_next    = left_reg - 4'd1;
                        if (left_reg == 4'd1) begin
                            if (off_cnt_reg == 4'd0) begin
                                do_finish = 1'b1;
                            end else begin
                                phase_next = PH_OFFSET;
                                left_next  = off_cnt_reg;
                            end
                        end
                    end
                    PH_OFFSET: begin
                        off_acc_next = off_merged;
                        left_next    = left_reg - 4'd1;
                        if (left_reg == 4'd1) begin
                            do_finish = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (do_header) begin
            if (in_byte_reg == 8'd0) begin
                res_valid  = 1'b1;
                res_kind   = KIND_END;
                phase_next = PH_DONE;
            end else begin
                len_cnt_next = hdr_len;
                off_cnt_next = hdr_off;
                if ((hdr_len > MAX_FIELD_BYTES) || (hdr_off > MAX_FIELD_BYTES)) begin
                    res_valid  = 1'b1;
                    res_kind   = KIND_BAD_SIZE;
                    phase_next = PH_DONE;
                end else begin
                    len_acc_next = '0;
                    off_acc_next = '0;
                    if (hdr_len != 4'd0) begin
                        phase_next = PH_LENGTH;
                        left_next  = hdr_len;
                    end else begin
                        phase_next = PH_OFFSET;
                        left_next  = hdr_off;
                    end
                end
            end
        end

        if (do_finish) begin
            res_valid     = 1'b1;
            res_vcn       = next_vcn_reg;
            res_len       = run_end - next_vcn_reg;
            res_sparse    = run_sparse;
            next_vcn_next = run_end;
            if (!run_sparse) begin
                cur_lcn_next = lcn_sum;
                res_lcn      = lcn_sum;
            end
            if (run_end == limit_reg) begin
                res_kind   = KIND_RUN_LIMIT;
                phase_next = PH_DONE;
            end else begin
                res_kind   = KIND_RUN;
                phase_next = PH_HEADER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_DONE;
            len_cnt_reg  <= '0;
            off_cnt_reg  <= '0;
            left_reg     <= '0;
            len_acc_reg  <= '0;
            off_acc_reg  <= '0;
            next_vcn_reg <= '0;
            cur_lcn_reg  <= '0;
            limit_reg    <= '0;
        end else begin
            phase_reg    <= phase_next;
            len_cnt_reg  <= len_cnt_next;
            off_cnt_reg  <= off_cnt_next;
            left_reg     <= left_next;
            len_acc_reg  <= len_acc_next;
            off_acc_reg  <= off_acc_next;
            next_vcn_reg <= next_vcn_next;
            cur_lcn_reg  <= cur_lcn_next;
            limit_reg    <= limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proceed && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed && res_valid) begin
            kind_reg   <= res_kind;
            vcn_reg    <= res_vcn;
            lcn_reg    <= res_lcn;
            length_reg <= res_len;
            sparse_reg <= res_sparse;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_run_vcn     = vcn_reg;
    assign m_run_lcn     = lcn_reg;
    assign m_run_length  = length_reg;
    assign m_run_sparse  = sparse_reg;

endmodule
